// ===== hw/rtl/heap_sort_by_key_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef HEAP_SORT_BY_KEY_UNIT_ASSERT_SVH
`define HEAP_SORT_BY_KEY_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/hsk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsk_pkg
// Shared constants and types of the heap sort unit.
// ----------------------------------------------------------------------------
package hsk_pkg;
  localparam int Capacity = 64;
  localparam int KeyBits  = 48;
  localparam int TagBits  = 16;
  localparam int AddrBits = $clog2(Capacity);
  localparam int CntBits  = $clog2(Capacity + 1);
  localparam int QDepth   = 2;

  // Word passed from the loader to the sort engine: a record and set flags.
  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [TagBits-1:0] tag;
    logic               keep;  // record is stored (room was left)
    logic               last;  // set ends with this word
  } rec_t;

  // Loader status toward the queue.
  typedef struct packed {
    logic push;
    rec_t rec;
  } ld_t;

  typedef enum logic [3:0] {
    S_LOAD, S_BUILD_NEXT, S_SIFT_LD, S_SIFT_RD, S_SIFT_CMP, S_SIFT_SWAP,
    S_EXT_RD, S_EXT_SWAP, S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
  } eng_state_t;
endpackage

// ===== hw/rtl/hsk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsk_front
// Input stage: masks invalid keys and classifies each word for the engine.
// ----------------------------------------------------------------------------
module hsk_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [hsk_pkg::KeyBits-1:0]  in_sort_key,
  input  logic                         in_key_valid,
  input  logic [hsk_pkg::TagBits-1:0]  in_record_tag,
  input  logic                         in_last_in,
  input  logic                         q_full,
  output hsk_pkg::ld_t                 ld
);
  logic [hsk_pkg::CntBits-1:0] cnt_r, cnt_nxt;
  logic                        acc;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  always_comb begin
    ld.push     = acc;
    ld.rec.key  = in_key_valid ? in_sort_key : '0;
    ld.rec.tag  = in_record_tag;
    ld.rec.keep = (cnt_r != hsk_pkg::CntBits'(hsk_pkg::Capacity));
    ld.rec.last = in_last_in;
    cnt_nxt     = cnt_r;
    if (acc) begin
      if (in_last_in) cnt_nxt = '0;
      else if (ld.rec.keep) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end
endmodule

// ===== hw/rtl/hsk_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsk_queue
// Short FIFO between loader and sort engine.
// ----------------------------------------------------------------------------
module hsk_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  hsk_pkg::ld_t  ld,
  output logic          q_full,
  output logic          q_valid,
  output hsk_pkg::rec_t q_rec,
  input  logic          q_pop
);
  localparam int PB = $clog2(hsk_pkg::QDepth);
  hsk_pkg::rec_t mem_r [hsk_pkg::QDepth];
  logic [PB-1:0] wp_r, rp_r;
  logic [PB:0]   cnt_r;
  logic          wr, rd;

  assign q_full  = (cnt_r == (PB+1)'(hsk_pkg::QDepth));
  assign q_valid = (cnt_r != '0);
  assign q_rec   = mem_r[rp_r];
  assign wr      = ld.push && !q_full;
  assign rd      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= ld.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PB+1)'(wr) - (PB+1)'(rd);
    end
  end
endmodule

// ===== hw/rtl/hsk_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsk_engine
// Record store and heapsort sequencer; streams sorted words through a
// one-entry output register.
// ----------------------------------------------------------------------------
module hsk_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  hsk_pkg::rec_t               q_rec,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [hsk_pkg::KeyBits-1:0] out_out_key,
  output logic [hsk_pkg::TagBits-1:0] out_out_tag,
  output logic                        out_out_last,
  output logic                        out_overflowed
);
  localparam int AB = hsk_pkg::AddrBits;
  localparam int CB = hsk_pkg::CntBits;
  localparam int KB = hsk_pkg::KeyBits;
  localparam int WB = hsk_pkg::KeyBits + hsk_pkg::TagBits;

  // Record memory, key above tag.
  logic [WB-1:0] mem_r [hsk_pkg::Capacity];
  logic [AB-1:0] ra_a, ra_b, wa_a, wa_b;
  logic          we_a, we_b;
  logic [WB-1:0] wd_a, wd_b, rd_a_r, rd_b_r;

  hsk_pkg::eng_state_t st_r, st_nxt;
  logic [CB-1:0] n_r, n_nxt, size_r, size_nxt, i_r, i_nxt;
  logic [CB:0]   node_r, node_nxt;
  logic [AB-1:0] best_r, best_nxt;
  logic [WB-1:0] node_w_r, node_w_nxt, best_w_r, best_w_nxt;
  logic          ovs_r, ovs_nxt;  // a record of the current set was dropped
  logic          ovf_r, ovf_nxt;
  logic          ov_r, ov_nxt;
  logic [WB-1:0] ow_r, ow_nxt;
  logic          ol_r, ol_nxt;
  logic [CB:0]   lc, rc;
  logic          lc_in, rc_in;
  logic          out_take;
  logic          last_word;

  // Two registered read ports (children, or root and heap end); two write
  // ports for swaps. The sifted record itself is kept in node_w_r.
  always_ff @(posedge clk) begin
    if (we_a) mem_r[wa_a] <= wd_a;
    if (we_b) mem_r[wa_b] <= wd_b;
    rd_a_r <= mem_r[ra_a];
    rd_b_r <= mem_r[ra_b];
  end

  assign lc    = {node_r[CB-1:0], 1'b1};
  assign rc    = lc + 1'b1;
  assign lc_in = lc < (CB+1)'(size_r);
  assign rc_in = rc < (CB+1)'(size_r);
  assign out_take  = !ov_r || out_pop;
  assign last_word = (i_r + 1'b1 == n_r);
  assign out_empty      = !ov_r;
  assign out_out_key    = ow_r[WB-1 -: hsk_pkg::KeyBits];
  assign out_out_tag    = ow_r[hsk_pkg::TagBits-1:0];
  assign out_out_last   = ol_r;
  assign out_overflowed = ovf_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hsk_pkg::S_LOAD:
        if (q_valid && q_rec.last) begin
          if (n_nxt == '0) st_nxt = hsk_pkg::S_LOAD;
          else st_nxt = hsk_pkg::S_BUILD_NEXT;
        end
      hsk_pkg::S_BUILD_NEXT:
        if (i_r == '0) st_nxt = hsk_pkg::S_EXT_RD;
        else st_nxt = hsk_pkg::S_SIFT_LD;
      hsk_pkg::S_SIFT_LD: st_nxt = hsk_pkg::S_SIFT_CMP;
      hsk_pkg::S_SIFT_RD: st_nxt = hsk_pkg::S_SIFT_CMP;
      hsk_pkg::S_SIFT_CMP: begin
        if (best_nxt == node_r[AB-1:0]) begin
          if (size_r == n_r) st_nxt = hsk_pkg::S_BUILD_NEXT;
          else st_nxt = hsk_pkg::S_EXT_RD;
        end else st_nxt = hsk_pkg::S_SIFT_SWAP;
      end
      hsk_pkg::S_SIFT_SWAP: st_nxt = hsk_pkg::S_SIFT_RD;
      hsk_pkg::S_EXT_RD:
        if (size_r <= CB'(1)) st_nxt = hsk_pkg::S_OUT_RD;
        else st_nxt = hsk_pkg::S_EXT_SWAP;
      hsk_pkg::S_EXT_SWAP: st_nxt = hsk_pkg::S_SIFT_RD;
      hsk_pkg::S_OUT_RD: st_nxt = hsk_pkg::S_OUT_WAIT;
      hsk_pkg::S_OUT_WAIT: st_nxt = hsk_pkg::S_OUT_HOLD;
      hsk_pkg::S_OUT_HOLD:
        if (out_take) begin
          if (last_word) st_nxt = hsk_pkg::S_LOAD;
          else st_nxt = hsk_pkg::S_OUT_RD;
        end
      default: st_nxt = hsk_pkg::S_LOAD;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    n_nxt = n_r; size_nxt = size_r; i_nxt = i_r; node_nxt = node_r;
    best_nxt = best_r; node_w_nxt = node_w_r; best_w_nxt = best_w_r;
    ovs_nxt = ovs_r; ovf_nxt = ovf_r; ov_nxt = ov_r; ow_nxt = ow_r; ol_nxt = ol_r;
    q_pop = 1'b0;
    ra_a = lc[AB-1:0]; ra_b = rc[AB-1:0];
    we_a = 1'b0; we_b = 1'b0; wa_a = '0; wa_b = '0; wd_a = '0; wd_b = '0;
    if (ov_r && out_pop) ov_nxt = 1'b0;
    case (st_r)
      hsk_pkg::S_LOAD: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (q_rec.keep) begin
            we_a = 1'b1; wa_a = n_r[AB-1:0]; wd_a = {q_rec.key, q_rec.tag};
            n_nxt = n_r + 1'b1;
          end else ovs_nxt = 1'b1;
          if (q_rec.last) begin
            size_nxt = n_nxt;
            i_nxt    = CB'(n_nxt >> 1);
          end
        end
      end
      hsk_pkg::S_BUILD_NEXT:
        if (i_r != '0) begin
          i_nxt = i_r - 1'b1;
          node_nxt = (CB+1)'(i_r - 1'b1);
          ra_a = AB'(i_r - 1'b1);
        end
      // Node record arrives; children are read at the same time.
      hsk_pkg::S_SIFT_LD: node_w_nxt = rd_a_r;
      hsk_pkg::S_SIFT_RD: ;
      // Strict compare, left child first, right child against the winner.
      hsk_pkg::S_SIFT_CMP: begin
        best_nxt = node_r[AB-1:0];
        best_w_nxt = node_w_r;
        if (lc_in && rd_a_r[WB-1 -: KB] > node_w_r[WB-1 -: KB]) begin
          best_nxt = lc[AB-1:0]; best_w_nxt = rd_a_r;
        end
        if (rc_in && rd_b_r[WB-1 -: KB] > best_w_nxt[WB-1 -: KB]) begin
          best_nxt = rc[AB-1:0]; best_w_nxt = rd_b_r;
        end
      end
      hsk_pkg::S_SIFT_SWAP: begin
        we_a = 1'b1; wa_a = node_r[AB-1:0]; wd_a = best_w_r;
        we_b = 1'b1; wa_b = best_r; wd_b = node_w_r;
        node_nxt = (CB+1)'(best_r);
      end
      hsk_pkg::S_EXT_RD: begin
        ra_a = '0; ra_b = AB'(size_r - 1'b1);
        if (size_r <= CB'(1)) i_nxt = '0;
      end
      hsk_pkg::S_EXT_SWAP: begin
        we_a = 1'b1; wa_a = '0; wd_a = rd_b_r;
        we_b = 1'b1; wa_b = AB'(size_r - 1'b1); wd_b = rd_a_r;
        node_w_nxt = rd_b_r;
        size_nxt = size_r - 1'b1;
        node_nxt = '0;
      end
      hsk_pkg::S_OUT_RD, hsk_pkg::S_OUT_WAIT: ra_a = i_r[AB-1:0];
      hsk_pkg::S_OUT_HOLD: begin
        ra_a = i_r[AB-1:0];
        if (out_take) begin
          ov_nxt  = 1'b1; ow_nxt = rd_a_r;
          ol_nxt  = last_word;
          ovf_nxt = ovs_r;
          i_nxt   = i_r + 1'b1;
          if (last_word) begin
            n_nxt   = '0;
            ovs_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hsk_pkg::S_LOAD; n_r <= '0; ov_r <= 1'b0; ovs_r <= 1'b0;
      ovf_r <= 1'b0; i_r <= '0; size_r <= '0; node_r <= '0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; ov_r <= ov_nxt; ovs_r <= ovs_nxt;
      ovf_r <= ovf_nxt; i_r <= i_nxt; size_r <= size_nxt; node_r <= node_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt; node_w_r <= node_w_nxt; best_w_r <= best_w_nxt;
    ow_r <= ow_nxt; ol_r <= ol_nxt;
  end
endmodule

// ===== hw/rtl/heap_sort_by_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_by_key_unit
// Collects key/tag records and returns them in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (key, key_valid, tag, last) enter through a push/full port.
//   A key with key_valid low is stored as zero. Up to 64 records are held;
//   extra records are dropped and every output word of that set shows
//   overflowed. The word with last_in starts the sort.
//   Results leave through an empty/pop port, ascending, out_last on the
//   final word. Equal keys come out in heapsort swap order.
// Timing:
//   Loading takes one word per cycle while the engine is loading; a word
//   passes through the input queue before it is written to the store.
//   The record memory has two registered read ports. Each sift level
//   reads the children, compares and swaps; a build sift starts by loading
//   the node record, an extraction step by reading and swapping the root
//   and the heap end. After the sort, each result is read, waited for and
//   loaded into the output register, one word at a time.
//   While a set is sorted or drained the 2-word input queue fills and full
//   rises; a stalled receiver simply holds the output word.
// Reset: synchronous, active low; empties queue and restarts a set.
// ----------------------------------------------------------------------------
module heap_sort_by_key_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [hsk_pkg::KeyBits-1:0] in_sort_key,
  input  logic                        in_key_valid,
  input  logic [hsk_pkg::TagBits-1:0] in_record_tag,
  input  logic                        in_last_in,
  output logic                        empty,
  input  logic                        pop,
  output logic [hsk_pkg::KeyBits-1:0] out_key,
  output logic [hsk_pkg::TagBits-1:0] out_tag,
  output logic                        out_last,
  output logic                        out_overflowed
);
  hsk_pkg::ld_t  ld;
  hsk_pkg::rec_t q_rec;
  logic          q_full, q_valid, q_pop;

  hsk_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_sort_key,
    .in_key_valid, .in_record_tag, .in_last_in, .q_full, .ld
  );

  hsk_queue u_queue (
    .clk, .rst_n, .ld, .q_full, .q_valid, .q_rec, .q_pop
  );

  hsk_engine u_engine (
    .clk, .rst_n, .q_valid, .q_rec, .q_pop,
    .out_empty(empty), .out_pop(pop), .out_out_key(out_key),
    .out_out_tag(out_tag), .out_out_last(out_last),
    .out_overflowed(out_overflowed)
  );
endmodule

// ===== hw/rtl/hsk_checker.sv =====
`timescale 1ns / 1ps
`include "heap_sort_by_key_unit_assert.svh"
// ----------------------------------------------------------------------------
// hsk_checker
// Port-level checks of the heap sort unit.
// ----------------------------------------------------------------------------
module hsk_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic [hsk_pkg::KeyBits-1:0] out_key,
  input logic                        out_last,
  input logic                        out_overflowed
);
  // Stalled output word holds.
  `HSK_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_key))
  // Keys of one set never decrease from word to word.
  `HSK_ASSERT_NXT(a_order, clk, rst_n, !empty && pop && !out_last,
    empty || out_key >= $past(out_key))
  // Overflow flag is constant within a set.
  `HSK_ASSERT_NXT(a_ovf, clk, rst_n, !empty && pop && !out_last,
    empty || out_overflowed == $past(out_overflowed))
endmodule

bind heap_sort_by_key_unit hsk_checker u_hsk_checker (
  .clk, .rst_n, .empty, .pop, .out_key, .out_last, .out_overflowed
);
